/* src/umf_pkg.sv */
// Shared types and codes for the unsigned minifloat codec.
package umf_pkg;

    typedef enum logic {
        OP_PACK   = 1'b0,
        OP_UNPACK = 1'b1
    } op_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_CLAMP_DOWN = 2'd1;
    localparam logic [1:0] ST_CLAMP_UP   = 2'd2;

    localparam logic [1:0] REG_FRAC_W  = 2'd0;
    localparam logic [1:0] REG_EXP_W   = 2'd1;
    localparam logic [1:0] REG_EXP_OFF = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // Settled configuration and the constants derived from it
    typedef struct packed {
        logic [4:0]        fw;
        logic [5:0]        cw;
        logic signed [9:0] bias;
        logic [9:0]        half;
        logic [27:0]       fmask;
        logic [62:0]       max_mag;
        logic [62:0]       min_mag;
        logic [10:0]       sub_exp;
        logic [10:0]       nrm_exp;
    } cfg_t;

endpackage

/* src/umf_cfg.sv */
// Configuration registers, range settling and derived format constants.
module umf_cfg
    import umf_pkg::*;
#(
    parameter int PACKED_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    localparam int EW_CAP = (PACKED_WIDTH - 2 < 10) ? PACKED_WIDTH - 2 : 10;
    localparam logic [6:0] PW7 = 7'(PACKED_WIDTH);

    logic [4:0] fw_reg;
    logic [3:0] ew_reg;
    logic [9:0] off_reg;
    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= 5'd10;
            ew_reg  <= 4'd5;
            off_reg <= 10'd0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAC_W:  fw_reg  <= wr_data[4:0];
                REG_EXP_W:   ew_reg  <= wr_data[3:0];
                REG_EXP_OFF: off_reg <= wr_data;
                default:     ;
            endcase
        end
    end

    // Settle ranges and derive constants
    always_comb
    begin
        logic [4:0]         fw_c;
        logic [3:0]         ew_c;
        logic signed [9:0]  b_c;
        logic [9:0]         half_c;
        logic signed [12:0] bias_s;
        logic signed [12:0] half_s;
        logic signed [12:0] fw_s;
        logic signed [12:0] max_e;
        logic signed [12:0] min_e;
        logic signed [12:0] nrm_e;
        logic [51:0]        max_m;

        fw_c = fw_reg;
        if (fw_c < 5'd2) fw_c = 5'd2;
        if (fw_c > 5'd28) fw_c = 5'd28;
        ew_c = ew_reg;
        if (ew_c < 4'd2) ew_c = 4'd2;
        if (ew_c > 4'(EW_CAP)) ew_c = 4'(EW_CAP);
        if ({2'b0, fw_c} + {3'b0, ew_c} > PW7) fw_c = 5'(PW7 - {3'b0, ew_c});
        b_c = $signed(off_reg);
        if (b_c < -10'sd400) b_c = -10'sd400;
        if (b_c > 10'sd400) b_c = 10'sd400;

        half_c = 10'd1 << (ew_c - 4'd1);
        bias_s = {{3{b_c[9]}}, b_c};
        half_s = $signed({3'b0, half_c});
        fw_s   = $signed({8'b0, fw_c});
        max_e  = half_s + bias_s - 13'sd3 + 13'sd1023;
        min_e  = bias_s - half_s - fw_s - 13'sd1 + 13'sd1023;
        nrm_e  = bias_s - half_s - 13'sd2 + 13'sd1023;
        max_m  = ~((52'd1 << (6'd52 - {1'b0, fw_c})) - 52'd1);

        cfg_next.fw      = fw_c;
        cfg_next.cw      = {1'b0, fw_c} + {2'b0, ew_c};
        cfg_next.bias    = b_c;
        cfg_next.half    = half_c;
        cfg_next.fmask   = (28'd1 << fw_c) - 28'd1;
        cfg_next.max_mag = {max_e[10:0], max_m};
        cfg_next.min_mag = {min_e[10:0], 52'd0};
        cfg_next.sub_exp = min_e[10:0];
        cfg_next.nrm_exp = nrm_e[10:0];
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

/* src/unsigned_minifloat_codec_core.sv */
// Top level: pipelined pack/unpack between binary64 and an unsigned minifloat.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | operation, value_bits, packed_word
//  out     | out_valid / out_ready| packed_out, value_out, status, negative_seen
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready always high)
//
// One item per cycle while the output is taken; the stages are the input register,
// clamp and exponent stage, rounding / normalise stage and output register.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears valid bits and the configuration to its defaults.
module unsigned_minifloat_codec_core
    import umf_pkg::*;
#(
    parameter int PACKED_WIDTH = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    operation,
    input  logic [63:0]             value_bits,
    input  logic [PACKED_WIDTH-1:0] packed_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PACKED_WIDTH-1:0] packed_out,
    output logic [63:0]             value_out,
    output logic [1:0]              status,
    output logic                    negative_seen,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t cfg;
    logic en;

    assign cfg_ready = 1'b1;

    umf_cfg #(.PACKED_WIDTH(PACKED_WIDTH)) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Global advance: hold everything while the output waits
    assign en       = !(out_valid && !out_ready);
    assign in_ready = en;

    // ---------------- stage A: input register ----------------
    logic                    a_valid_reg;
    op_t                     a_op_reg;
    logic [63:0]             a_value_reg;
    logic [PACKED_WIDTH-1:0] a_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            a_op_reg    <= op_t'(operation);
            a_value_reg <= value_bits;
            a_word_reg  <= packed_word;
        end
    end

    // ---------------- stage B: clamp, exponent, field split ----------------
    logic        b_valid_reg;
    op_t         b_op_reg;
    logic        b_zero_reg, b_zero_next;
    logic        b_neg_reg, b_neg_next;
    logic [1:0]  b_status_reg, b_status_next;
    logic [52:0] b_m_reg, b_m_next;
    logic [5:0]  b_sh_reg, b_sh_next;
    logic [10:0] b_base_reg, b_base_next;
    logic        b_usub_reg, b_usub_next;
    logic [9:0]  b_wf_reg, b_wf_next;
    logic [27:0] b_wfrac_reg, b_wfrac_next;

    always_comb
    begin
        logic [62:0]             mag;
        logic                    is_nan;
        logic                    over;
        logic                    under;
        logic [62:0]             ub;
        logic signed [12:0]      d_s;
        logic signed [12:0]      sh_s;
        logic                    sub;
        logic [PACKED_WIDTH-1:0] code_mask;
        logic [PACKED_WIDTH-1:0] w;

        mag    = a_value_reg[62:0];
        is_nan = (mag[62:52] == 11'h7FF) && (mag[51:0] != 52'd0);
        over   = is_nan || (mag > cfg.max_mag);
        under  = !over && (mag < cfg.min_mag);
        ub     = over ? cfg.max_mag : (under ? cfg.min_mag : mag);
        d_s    = $signed({2'b0, ub[62:52]}) - 13'sd1021 + $signed({3'b0, cfg.half})
                 - {{3{cfg.bias[9]}}, cfg.bias};
        sub    = d_s < 13'sd1;
        sh_s   = 13'sd51 - $signed({8'b0, cfg.fw}) + (sub ? (13'sd1 - d_s) : 13'sd0);

        b_zero_next   = (mag == 63'd0);
        b_neg_next    = a_value_reg[63] && !is_nan && !b_zero_next;
        b_status_next = b_zero_next ? ST_OK :
                        (over ? ST_CLAMP_DOWN : (under ? ST_CLAMP_UP : ST_OK));
        b_m_next      = {1'b1, ub[51:0]};
        b_sh_next     = sh_s[5:0];
        b_base_next   = sub ? 11'd0 : 11'(d_s - 13'sd1);

        // unpack: drop bits above the code, split exponent and fraction
        code_mask    = PACKED_WIDTH'((64'd1 << cfg.cw) - 64'd1);
        w            = a_word_reg & code_mask;
        b_wf_next    = 10'(w >> cfg.fw);
        b_wfrac_next = 28'(w) & cfg.fmask;
        b_usub_next  = (b_wf_next == 10'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_op_reg     <= a_op_reg;
            b_zero_reg   <= b_zero_next;
            b_neg_reg    <= b_neg_next;
            b_status_reg <= b_status_next;
            b_m_reg      <= b_m_next;
            b_sh_reg     <= b_sh_next;
            b_base_reg   <= b_base_next;
            b_usub_reg   <= b_usub_next;
            b_wf_reg     <= b_wf_next;
            b_wfrac_reg  <= b_wfrac_next;
        end
    end

    // ---------------- stage C: round half up / normalise ----------------
    logic        c_valid_reg;
    op_t         c_op_reg;
    logic        c_zero_reg;
    logic        c_neg_reg;
    logic [1:0]  c_status_reg;
    logic [10:0] c_base_reg;
    logic [29:0] c_r_reg, c_r_next;
    logic [63:0] c_value_reg, c_value_next;

    always_comb
    begin
        logic [52:0] t;
        logic [4:0]  p;
        logic [10:0] ex;
        logic [51:0] mant;

        t        = b_m_reg >> b_sh_reg;
        c_r_next = 30'((t + 53'd1) >> 1);

        // leading one of a linear code
        p = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (b_wfrac_reg[i]) p = 5'(i);
        end

        if (b_usub_reg)
        begin
            ex   = cfg.sub_exp + {6'b0, p};
            mant = 52'({24'b0, b_wfrac_reg} << (6'd52 - {1'b0, p}));
        end
        else
        begin
            ex   = cfg.nrm_exp + {1'b0, b_wf_reg};
            mant = 52'({24'b0, b_wfrac_reg} << (6'd52 - {1'b0, cfg.fw}));
        end

        if (b_usub_reg && (b_wfrac_reg == 28'd0))
            c_value_next = 64'd0;
        else
            c_value_next = {1'b0, ex, mant};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_op_reg     <= b_op_reg;
            c_zero_reg   <= b_zero_reg;
            c_neg_reg    <= b_neg_reg;
            c_status_reg <= b_status_reg;
            c_base_reg   <= b_base_reg;
            c_r_reg      <= c_r_next;
            c_value_reg  <= c_value_next;
        end
    end

    // ---------------- stage D: assemble code, output register ----------------
    logic                    out_valid_reg;
    logic [PACKED_WIDTH-1:0] packed_reg, packed_next;
    logic [63:0]             value_reg, value_next;
    logic [1:0]              status_reg, status_next;
    logic                    neg_reg, neg_next;

    always_comb
    begin
        packed_next = '0;
        value_next  = '0;
        status_next = ST_OK;
        neg_next    = 1'b0;
        if (c_op_reg == OP_PACK)
        begin
            // a rounding carry out of the fraction lands in the exponent
            if (!c_zero_reg)
                packed_next = PACKED_WIDTH'({53'b0, c_base_reg} << cfg.fw)
                              + PACKED_WIDTH'(c_r_reg);
            status_next = c_status_reg;
            neg_next    = c_neg_reg;
        end
        else
        begin
            value_next = c_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            packed_reg <= packed_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            neg_reg    <= neg_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign packed_out    = packed_reg;
    assign value_out     = value_reg;
    assign status        = status_reg;
    assign negative_seen = neg_reg;

    // ---------------- assertions ----------------
    a_unpack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (value_out != 64'd0)) |->
            ((packed_out == '0) && (status == ST_OK) && !negative_seen))
        else $error("unpack result carries pack fields");

    a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && negative_seen) |-> (packed_out != '0))
        else $error("negative input packed to zero");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 in_ready ##1 in_ready ##1 in_ready |=> out_valid)
        else $error("transfer lost in pipeline");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the unsigned minifloat codec: random and directed pack/unpack.
module testbench;
    import umf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = 31;
    localparam int CYCLE_LIMIT = 400000;
    // index with no register behind it; the write must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic          operation;
        logic [63:0]   value_bits;
        logic [PW-1:0] packed_word;
    } codec_item_t;

    typedef struct {
        logic [PW-1:0] packed_out;
        logic [63:0]   value_out;
        logic [1:0]    status;
        logic          negative_seen;
    } codec_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic          operation = 1'b0;
    logic [63:0]   value_bits = '0;
    logic [PW-1:0] packed_word = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [PW-1:0] packed_out;
    logic [63:0]   value_out;
    logic [1:0]    status;
    logic          negative_seen;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    unsigned_minifloat_codec_core #(.PACKED_WIDTH(PW)) dut (.*);

    // Testbench copy of the configuration registers
    logic [4:0] fw_reg = 5'd10;
    logic [3:0] ew_reg = 4'd5;
    logic [9:0] off_reg = 10'd0;

    codec_item_t   pending_items[$];
    codec_result_t expected_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    int sender_idle_pct = 19;
    int receiver_idle_pct = 77;

    always #5 clk = ~clk;

    function automatic real pow2(int e);
        return $bitstoreal(64'(e + 1023) << 52);
    endfunction

    // Bit-exact conversion under the current settled configuration
    function automatic codec_result_t convert(codec_item_t it);
        codec_result_t r;
        int fw, ew, bias, half, idx, cw, e;
        logic [63:0] fmask, mag, ub, frac, w;
        real range, minv, maxv, u, f, rv;
        logic is_nan;
        fw = fw_reg;
        ew = ew_reg;
        bias = $signed(off_reg);
        if (fw < 2) fw = 2;
        if (fw > 28) fw = 28;
        if (ew < 2) ew = 2;
        if (ew > 10) ew = 10;
        if (ew > PW - 2) ew = PW - 2;
        if (fw + ew > PW) fw = PW - ew;
        if (bias < -400) bias = -400;
        if (bias > 400) bias = 400;
        half = 1 << (ew - 1);
        fmask = (64'd1 << fw) - 1;
        range = 2.0 * real'(64'd1 << fw);
        minv = pow2(bias - half) / range;
        maxv = (0.5 + real'(fmask) / range) * pow2(half + bias - 2);
        r = '{default: '0};
        if (it.operation == OP_PACK) begin
            mag = {1'b0, it.value_bits[62:0]};
            is_nan = (mag[62:52] == 11'h7FF) && (mag[51:0] != 0);
            if (mag != 0) begin
                u = $bitstoreal(mag);
                if (!is_nan && it.value_bits[63]) r.negative_seen = 1'b1;
                if (is_nan || u > maxv) begin
                    u = maxv;
                    r.status = ST_CLAMP_DOWN;
                end else if (u < minv) begin
                    u = minv;
                    r.status = ST_CLAMP_UP;
                end
                ub = $realtobits(u);
                idx = int'(ub[62:52]) - 1022;
                f = $bitstoreal({ub[63], 11'd1022, ub[51:0]});
                idx += half + 1 - bias;
                if (idx < 1) begin
                    idx = 0;
                    f = u / minv + 0.5;
                end else begin
                    f = (f - 0.5) * range + 0.5;
                end
                frac = 64'($rtoi(f));
                if (frac > fmask) begin
                    frac = 0;
                    idx++;
                end
                r.packed_out = PW'((64'(idx) << fw) | frac);
            end
        end else begin
            cw = fw + ew;
            w = 64'(it.packed_word) & ((64'd1 << cw) - 1);
            if (w == 0) rv = 0.0;
            else if (w <= fmask) rv = real'(w) * minv;
            else begin
                e = int'(w >> fw) + bias - half - 1;
                rv = (0.5 + real'(w & fmask) / range) * pow2(e);
            end
            r.value_out = $realtobits(rv);
        end
        return r;
    endfunction

    // Input driver: offers queued items, records the prediction on each transfer
    always @(posedge clk) begin
        codec_item_t it;
        logic nxt_valid;
        nxt_valid = in_valid;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                it.operation = operation;
                it.value_bits = value_bits;
                it.packed_word = packed_word;
                expected_results.push_back(convert(it));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_items.size() != 0
                && $urandom_range(99) >= sender_idle_pct) begin
                it = pending_items.pop_front();
                operation <= it.operation;
                value_bits <= it.value_bits;
                packed_word <= it.packed_word;
                nxt_valid = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
        in_valid <= nxt_valid;
    end

    // Output monitor: compares each transfer with the oldest prediction
    always @(posedge clk) begin
        codec_result_t want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: packed %h value %h",
                    packed_out, value_out);
            end else begin
                want = expected_results.pop_front();
                if (packed_out !== want.packed_out || value_out !== want.value_out
                    || status !== want.status || negative_seen !== want.negative_seen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %0d %b got %h %h %0d %b",
                            want.packed_out, want.value_out, want.status,
                            want.negative_seen, packed_out, value_out, status,
                            negative_seen);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Register write; cfg_valid stays high so writes can follow back to back
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_FRAC_W:  fw_reg = data[4:0];
            REG_EXP_W:   ew_reg = data[3:0];
            REG_EXP_OFF: off_reg = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic add_pack(logic [63:0] v);
        pending_items.push_back('{OP_PACK, v, PW'($urandom)});
    endtask

    task automatic add_unpack(logic [PW-1:0] w);
        pending_items.push_back('{OP_UNPACK, {$urandom, $urandom}, w});
    endtask

    // Random items shaped around the current exponent window
    task automatic add_random(int n);
        int fw, ew, bias, half, t, b;
        logic [63:0] v;
        logic [51:0] m;
        fw = fw_reg;
        ew = ew_reg;
        bias = $signed(off_reg);
        if (fw < 2) fw = 2;
        if (fw > 28) fw = 28;
        if (ew < 2) ew = 2;
        if (ew > 10) ew = 10;
        if (fw + ew > PW) fw = PW - ew;
        if (bias < -400) bias = -400;
        if (bias > 400) bias = 400;
        half = 1 << (ew - 1);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: add_pack({$urandom, $urandom});
                1, 2, 3, 4, 5: begin
                    t = bias - half - fw - 4 + $urandom_range(2 * half + fw + 8);
                    b = t + 1023;
                    if (b < 0) b = 0;
                    if (b > 2046) b = 2046;
                    m = {$urandom, $urandom};
                    if ($urandom_range(7) == 0) m = '1;
                    v = {1'($urandom), 11'(b), m};
                    add_pack(v);
                end
                6: add_unpack(PW'($urandom));
                7: add_unpack(PW'($urandom_range((1 << fw) - 1)));
                default: add_unpack(PW'($urandom) & PW'((64'd1 << (fw + ew)) - 1));
            endcase
        end
    endtask

    initial begin
        int settings[10][3] = '{
            '{2, 2, 0}, '{28, 2, 400}, '{2, 10, -400}, '{28, 10, 0}, '{21, 10, 400},
            '{0, 0, -400}, '{31, 15, 511}, '{12, 6, -123}, '{5, 3, 77}, '{23, 8, -512}};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed items under reset configuration
        add_pack(64'h0000_0000_0000_0000);
        add_pack(64'h8000_0000_0000_0000);
        add_pack(64'h7FF0_0000_0000_0000);
        add_pack(64'hFFF0_0000_0000_0000);
        add_pack(64'h7FF8_0000_0000_0001);
        add_pack(64'h0000_0000_0000_0001);
        add_pack(64'h000F_FFFF_FFFF_FFFF);
        add_pack(64'h7FEF_FFFF_FFFF_FFFF);
        add_pack(64'h3FF0_0000_0000_0000);
        add_pack(64'hBFF8_0000_0000_0000);
        add_pack(64'h3FEF_FFFF_FFFF_FFFF);
        add_pack(64'h3F00_0000_0000_0000);
        add_pack(64'hFFFF_FFFF_FFFF_FFFF);
        add_unpack('0);
        add_unpack(PW'(1));
        add_unpack(PW'(10'h3FF));
        add_unpack(PW'(16'h7FFF));
        add_unpack('1);
        add_unpack(PW'(16'h0400));
        drain();
        for (int p = 0; p < 10; p++) begin
            if (p == 4) begin
                sender_idle_pct = 77;
                receiver_idle_pct = 19;
            end else if (p == 8) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            write_reg(REG_FRAC_W, CFG_DATA_W'(settings[p][0]));
            write_reg(REG_EXP_W, CFG_DATA_W'(settings[p][1]));
            write_reg(REG_EXP_OFF, CFG_DATA_W'(settings[p][2]));
            if (p == 5) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            add_random(55);
            drain();
        end
        $display("covered %0d results over ten register settings, extremes included",
            results_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end
endmodule
